// ----- design/lightmap_skyline_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef LIGHTMAP_SKYLINE_ALLOCATOR_DEFINES_SVH
`define LIGHTMAP_SKYLINE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while the active-low reset is asserted.
`define LSA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while the active-low reset is asserted.
`define LSA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lsa_pkg.sv -----
// Shared constants, types and helpers of the lightmap skyline allocator.
package lsa_pkg;
    localparam int BLOCK_COLUMNS_DEF = 128;
    localparam int BLOCK_ROWS_DEF    = 128;
    localparam int MAX_BLOCKS_DEF    = 64;
    localparam int SCAN_WINDOW_DEF   = 4;

    localparam int EXTENT_W     = 11;
    localparam int EXTENT_SHIFT = 4;
    localparam int SIZE_W       = EXTENT_W - EXTENT_SHIFT + 1;
    localparam int BLOCK_IDX_W  = 6;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED    = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_BLOCK  = 2'd2
    } t_status;

    // Rectangle size in texels from a surface extent.
    function automatic logic [SIZE_W-1:0] extent_to_size(input logic [EXTENT_W-1:0] extent);
        return SIZE_W'(extent >> EXTENT_SHIFT) + SIZE_W'(1);
    endfunction
endpackage

// ----- design/lsa_channels.sv -----
// Request and result channel interfaces of the allocator.
interface lsa_req_if;
    import lsa_pkg::*;
    logic                valid;
    logic                ready;
    logic [EXTENT_W-1:0] extent_s;
    logic [EXTENT_W-1:0] extent_t;
    modport source (output valid, output extent_s, output extent_t, input ready);
    modport sink (input valid, input extent_s, input extent_t, output ready);
endinterface

interface lsa_res_if;
    import lsa_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [BLOCK_IDX_W-1:0] block_index;
    logic [POS_W-1:0]       pos_s;
    logic [POS_W-1:0]       pos_t;
    t_status                status;
    modport source (output valid, output block_index, output pos_s, output pos_t,
                    output status, input ready);
    modport sink (input valid, input block_index, input pos_s, input pos_t,
                  input status, output ready);
endinterface

// ----- design/lightmap_skyline_allocator.sv -----
// Flow: an oversize request goes from setup straight to the result; otherwise the scan reads
// one column height at a time, and then the skyline is raised over the request width, or a
// fresh block is opened and swept over all BLOCK_COLUMNS columns. One item at a time: the
// scan loop over the single read port of the height RAM sets the rate.
// Reset: synchronous; block 0 is then swept to zero and no item
// is accepted until the sweep ends.
`include "lightmap_skyline_allocator_defines.svh"

module lightmap_skyline_allocator #(
    parameter int BLOCK_COLUMNS = lsa_pkg::BLOCK_COLUMNS_DEF,
    parameter int BLOCK_ROWS    = lsa_pkg::BLOCK_ROWS_DEF,
    parameter int MAX_BLOCKS    = lsa_pkg::MAX_BLOCKS_DEF,
    parameter int SCAN_WINDOW   = lsa_pkg::SCAN_WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsa_req_if.sink   i_req,
    lsa_res_if.source o_res
);
    import lsa_pkg::*;

    localparam int CIW   = $clog2(BLOCK_COLUMNS + 1);
    localparam int HW    = $clog2(BLOCK_ROWS + 1);
    localparam int NW0   = (CIW > HW) ? CIW : HW;
    localparam int NW    = ((NW0 > SIZE_W) ? NW0 : SIZE_W) + 1;
    localparam int BW    = $clog2(MAX_BLOCKS + 1);
    localparam int DEPTH = MAX_BLOCKS * BLOCK_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_ISSUE = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [SIZE_W-1:0]      r_w, n_w;
    logic [SIZE_W-1:0]      r_h, n_h;
    logic [CIW-1:0]         r_limit, n_limit;
    logic [BW-1:0]          r_blk, n_blk;
    logic [AW-1:0]          r_base, n_base;
    logic [BW-1:0]          r_blocks, n_blocks;
    logic [CIW-1:0]         r_i, n_i;
    logic [SIZE_W-1:0]      r_j, n_j;
    logic [CIW-1:0]         r_col, n_col;
    logic [HW-1:0]          r_top, n_top;
    logic [HW-1:0]          r_best, n_best;
    logic                   r_found, n_found;
    logic [CIW-1:0]         r_s, n_s;
    logic [HW-1:0]          r_t, n_t;
    logic [HW-1:0]          r_wval, n_wval;
    t_status                r_status, n_status;
    logic                   r_emit, n_emit;
    logic                   r_res_valid, n_res_valid;
    logic [BLOCK_IDX_W-1:0] r_res_blk, n_res_blk;
    logic [POS_W-1:0]       r_res_s, n_res_s;
    logic [POS_W-1:0]       r_res_t, n_res_t;
    t_status                r_res_status, n_res_status;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [HW-1:0]          rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [HW-1:0]          wr_data;

    logic [BW-1:0]          first_blk;
    logic [HW-1:0]          best_init;
    logic                   too_large;
    logic                   col_tall;
    logic                   col_at_best;
    logic [HW-1:0]          top_new;
    logic                   cand_last;
    logic                   cand_end;
    logic [CIW-1:0]         scan_next_i;

    assign first_blk = (int'(r_blocks) > SCAN_WINDOW) ? BW'(int'(r_blocks) - SCAN_WINDOW) : '0;
    assign best_init = HW'(NW'(BLOCK_ROWS) + NW'(1) - NW'(r_h));
    assign too_large = (NW'(r_w) >= NW'(BLOCK_COLUMNS)) || (NW'(r_h) > NW'(BLOCK_ROWS));

    assign col_tall    = (NW'(rd_data) + NW'(r_h)) > NW'(BLOCK_ROWS);
    assign col_at_best = rd_data >= r_best;
    assign top_new     = (rd_data > r_top) ? rd_data : r_top;
    assign cand_last   = (r_j + SIZE_W'(1)) == r_w;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_w          = r_w;
        n_h          = r_h;
        n_limit      = r_limit;
        n_blk        = r_blk;
        n_base       = r_base;
        n_blocks     = r_blocks;
        n_i          = r_i;
        n_j          = r_j;
        n_col        = r_col;
        n_top        = r_top;
        n_best       = r_best;
        n_found      = r_found;
        n_s          = r_s;
        n_t          = r_t;
        n_wval       = r_wval;
        n_status     = r_status;
        n_emit       = r_emit;
        n_res_valid  = r_res_valid && !o_res.ready;
        n_res_blk    = r_res_blk;
        n_res_s      = r_res_s;
        n_res_t      = r_res_t;
        n_res_status = r_res_status;
        rd_en        = 1'b0;
        rd_addr      = r_base + AW'(r_col);
        wr_en        = 1'b0;
        wr_addr      = r_base + AW'(r_col);
        wr_data      = r_wval;
        cand_end     = 1'b0;
        scan_next_i  = r_i + CIW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_w     = extent_to_size(i_req.extent_s);
                    n_h     = extent_to_size(i_req.extent_t);
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (too_large) begin
                    n_status = ST_TOO_LARGE;
                    n_state  = S_DONE;
                end else begin
                    n_limit = CIW'(NW'(BLOCK_COLUMNS) - NW'(r_w));
                    n_blk   = first_blk;
                    n_base  = AW'(int'(first_blk) * BLOCK_COLUMNS);
                    n_i     = '0;
                    n_j     = '0;
                    n_col   = '0;
                    n_top   = '0;
                    n_best  = best_init;
                    n_found = 1'b0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                rd_en   = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                priority if (col_tall) begin
                    // skip past the tall column and one more
                    scan_next_i = r_col + CIW'(2);
                    cand_end    = 1'b1;
                end else if (col_at_best) begin
                    cand_end = 1'b1;
                end else if (cand_last) begin
                    n_s      = r_i;
                    n_t      = top_new;
                    n_best   = top_new;
                    n_found  = 1'b1;
                    cand_end = 1'b1;
                end else begin
                    n_j     = r_j + SIZE_W'(1);
                    n_col   = r_col + CIW'(1);
                    n_top   = top_new;
                    rd_en   = 1'b1;
                    rd_addr = r_base + AW'(r_col + CIW'(1));
                end

                if (cand_end) begin
                    n_i   = scan_next_i;
                    n_j   = '0;
                    n_col = scan_next_i;
                    n_top = '0;
                    priority if (scan_next_i < r_limit) begin
                        rd_en   = 1'b1;
                        rd_addr = r_base + AW'(scan_next_i);
                    end else if (n_found) begin
                        n_col   = n_s;
                        n_wval  = HW'(NW'(n_t) + NW'(r_h));
                        n_state = S_WRITE;
                    end else if ((NW'(r_blk) + NW'(1)) < NW'(r_blocks)) begin
                        // advance to the next block of the window
                        n_blk   = r_blk + BW'(1);
                        n_base  = r_base + AW'(BLOCK_COLUMNS);
                        n_i     = '0;
                        n_col   = '0;
                        n_best  = best_init;
                        rd_en   = 1'b1;
                        rd_addr = r_base + AW'(BLOCK_COLUMNS);
                    end else if (int'(r_blocks) >= MAX_BLOCKS) begin
                        n_status = ST_NO_BLOCK;
                        n_state  = S_DONE;
                    end else begin
                        // open a fresh block right after the last one
                        n_blk    = r_blocks;
                        n_base   = r_base + AW'(BLOCK_COLUMNS);
                        n_blocks = r_blocks + BW'(1);
                        n_s      = '0;
                        n_t      = '0;
                        n_col    = '0;
                        n_wval   = HW'(r_h);
                        n_emit   = 1'b1;
                        n_state  = S_FILL;
                    end
                end
            end
            S_FILL: begin
                wr_en   = 1'b1;
                wr_data = (NW'(r_col) < NW'(r_w)) ? r_wval : '0;
                n_col   = r_col + CIW'(1);
                if (r_col == CIW'(BLOCK_COLUMNS - 1)) begin
                    n_status = ST_PLACED;
                    n_state  = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_WRITE: begin
                wr_en = 1'b1;
                n_col = r_col + CIW'(1);
                n_j   = r_j + SIZE_W'(1);
                if (cand_last) begin
                    n_status = ST_PLACED;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_res_valid || o_res.ready) begin
                    n_res_valid  = 1'b1;
                    n_res_status = r_status;
                    if (r_status == ST_PLACED) begin
                        n_res_blk = BLOCK_IDX_W'(r_blk);
                        n_res_s   = POS_W'(r_s);
                        n_res_t   = POS_W'(r_t);
                    end else begin
                        n_res_blk = '0;
                        n_res_s   = '0;
                        n_res_t   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_blocks    <= BW'(1);
            r_res_valid <= 1'b0;
            r_emit      <= 1'b0;
            r_col       <= '0;
            r_base      <= '0;
            r_w         <= '0;
        end else begin
            r_state     <= n_state;
            r_blocks    <= n_blocks;
            r_res_valid <= n_res_valid;
            r_emit      <= n_emit;
            r_col       <= n_col;
            r_base      <= n_base;
            r_w         <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h          <= n_h;
        r_limit      <= n_limit;
        r_blk        <= n_blk;
        r_i          <= n_i;
        r_j          <= n_j;
        r_top        <= n_top;
        r_best       <= n_best;
        r_found      <= n_found;
        r_s          <= n_s;
        r_t          <= n_t;
        r_wval       <= n_wval;
        r_status     <= n_status;
        r_res_blk    <= n_res_blk;
        r_res_s      <= n_res_s;
        r_res_t      <= n_res_t;
        r_res_status <= n_res_status;
    end

    lsa_height_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (HW)
    ) u_heights (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_res.valid       = r_res_valid;
    assign o_res.block_index = r_res_blk;
    assign o_res.pos_s       = r_res_s;
    assign o_res.pos_t       = r_res_t;
    assign o_res.status      = r_res_status;

    `LSA_ASSERT_IMP(a_blocks_range, i_clk, i_rst_n, 1'b1,
        (r_blocks != '0) && (int'(r_blocks) <= MAX_BLOCKS), "block count out of range")
    `LSA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready,
        !i_req.ready, "request taken while an item is in work")
    `LSA_ASSERT_IMP(a_scan_in_use, i_clk, i_rst_n, r_state == S_SCAN,
        r_blk < r_blocks, "scan reached a block not in use")
    `LSA_ASSERT_IMP(a_write_in_block, i_clk, i_rst_n, r_state == S_WRITE,
        NW'(r_col) < NW'(BLOCK_COLUMNS), "skyline write left the block")
    `LSA_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, o_res.valid && (o_res.status != ST_PLACED),
        (o_res.block_index == '0) && (o_res.pos_s == '0) && (o_res.pos_t == '0),
        "error result carries a position")
endmodule

// ----- design/lsa_height_ram.sv -----
// Column height memory: one write port and one registered read port.
module lsa_height_ram #(
    parameter int DEPTH = lsa_pkg::MAX_BLOCKS_DEF * lsa_pkg::BLOCK_COLUMNS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(lsa_pkg::BLOCK_ROWS_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
